>>> rtl/core/ptgp_pkg.sv
// ---------------------------------------------------------------------------
// ptgp_pkg
// Shared types and constants for the pixel to ground plane mapper.
// ---------------------------------------------------------------------------
package ptgp_pkg;

   localparam int IMG_WIDTH  = 640;
   localparam int IMG_HEIGHT = 480;

   // quotient bits: 41 integer bits plus one rounding bit
   localparam int DIV_BITS   = 42;
   // s1..s6, divider entry, divider steps, round, output
   localparam int NUM_STAGES = 7 + DIV_BITS + 2;

   localparam logic [DIV_BITS-1:0] Q_CAP = DIV_BITS'(1) << 40;

   typedef enum logic [2:0] {
      CSR_INV_FOCAL_X   = 3'd0,
      CSR_INV_FOCAL_Y   = 3'd1,
      CSR_SIN_TILT      = 3'd2,
      CSR_COS_TILT      = 3'd3,
      CSR_CAMERA_X      = 3'd4,
      CSR_CAMERA_Y      = 3'd5,
      CSR_CAMERA_HEIGHT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [61:0]         rem;
      logic [DIV_BITS-1:0] quo;
      logic [DIV_BITS-1:0] nlow;
      logic                ovf;
      logic                neg;
   } lane_type;

endpackage

>>> rtl/core/pixel_to_ground_plane.sv
// Throughput: one transaction per cycle when rsp is not stalled; set by the
// 42-step restoring divider, one quotient bit per pipeline stage, two lanes
// (x and y) side by side. A stall at rsp freezes the whole pipeline. Reset is
// synchronous: it clears valid bits and loads the register reset values
// (cos_tilt = 1.0).
// ---------------------------------------------------------------------------
// pixel_to_ground_plane
// Projects a pixel ray through a tilted pinhole camera onto the plane z = 0.
// ---------------------------------------------------------------------------
module pixel_to_ground_plane (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // pixel_col[11:0], pixel_row[23:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // base_x[31:0], base_y[63:32]
   output logic [1:0]  rsp_tuser,    // ray_upward[0], saturated[1]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import ptgp_pkg::*;

   logic adv;
   logic [NUM_STAGES-1:0] vld_ff;

   // configuration
   logic [31:0]        ifx_ff, ify_ff;
   logic signed [15:0] st_ff, ct_ff;
   logic signed [31:0] camx_ff, camy_ff;
   logic [30:0]        h_ff;

   // s1
   logic signed [13:0] du2_in, dv2_in, du2_ff;
   logic signed [29:0] pa_in, pb_in, pa_ff, pb_ff;
   // s2
   logic signed [46:0] xn_in, xn_ff;
   logic signed [62:0] sy_in, sz_in, sy_ff, sz_ff;
   // s3
   logic signed [63:0] r_in [0:1];
   logic signed [63:0] r_ff [0:1];
   logic signed [63:0] rz_in, rz_ff;
   // s4
   logic signed [63:0] rneg [0:1];
   logic signed [63:0] dneg;
   logic [61:0] mag_in [0:1];
   logic [61:0] mag_ff [0:1];
   logic [1:0]  neg4_in, neg4_ff;
   logic [61:0] d4_in, d4_ff;
   logic        up4_ff;
   // s5
   logic [61:0] pl_in [0:1];
   logic [61:0] ph_in [0:1];
   logic [61:0] pl_ff [0:1];
   logic [61:0] ph_ff [0:1];
   logic [1:0]  neg5_ff;
   logic [61:0] d5_ff;
   logic        up5_ff;
   // s6
   logic [92:0] prod_in [0:1];
   logic [92:0] prod_ff [0:1];
   logic [1:0]  neg6_ff;
   logic [61:0] d6_ff;
   logic        up6_ff;
   // divider
   logic [93:0] num [0:1];
   lane_type    lane_in [0:DIV_BITS][0:1];
   lane_type    lane_ff [0:DIV_BITS][0:1];
   logic [61:0] dd_ff [0:DIV_BITS];
   logic        upd_ff [0:DIV_BITS];
   logic [62:0] div_r2 [0:DIV_BITS-1][0:1];
   logic [62:0] div_df [0:DIV_BITS-1][0:1];
   // round
   logic [DIV_BITS:0]   tp1 [0:1];
   logic [DIV_BITS-1:0] qr [0:1];
   logic [DIV_BITS-1:0] qc [0:1];
   logic signed [42:0]  cam43 [0:1];
   logic signed [42:0]  v_in [0:1];
   logic signed [42:0]  v_ff [0:1];
   logic                upr_ff;
   // output
   logic [31:0] o_in [0:1];
   logic [31:0] o_ff [0:1];
   logic [1:0]  s_in;
   logic        sat_ff, upo_ff;

   assign adv        = !vld_ff[NUM_STAGES-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[NUM_STAGES-1];
   assign rsp_tdata  = {o_ff[1], o_ff[0]};
   assign rsp_tuser  = {sat_ff, upo_ff};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ifx_ff  <= '0;
         ify_ff  <= '0;
         st_ff   <= '0;
         ct_ff   <= 16'sd16384;
         camx_ff <= '0;
         camy_ff <= '0;
         h_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_INV_FOCAL_X:   ifx_ff  <= csr_wdata;
            CSR_INV_FOCAL_Y:   ify_ff  <= csr_wdata;
            CSR_SIN_TILT:      st_ff   <= csr_wdata[15:0];
            CSR_COS_TILT:      ct_ff   <= csr_wdata[15:0];
            CSR_CAMERA_X:      camx_ff <= csr_wdata;
            CSR_CAMERA_Y:      camy_ff <= csr_wdata;
            CSR_CAMERA_HEIGHT: h_ff    <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_STAGES-2:0], req_tvalid};
      end
   end

   always_comb begin
      // s1: centre and fold tilt into the row offset
      du2_in = $signed({1'b0, req_tdata[11:0], 1'b0}) - 14'(IMG_WIDTH);
      dv2_in = $signed({1'b0, req_tdata[23:12], 1'b0}) - 14'(IMG_HEIGHT);
      pa_in  = st_ff * dv2_in;
      pb_in  = ct_ff * dv2_in;
      // s2
      xn_in = du2_ff * $signed({1'b0, ifx_ff});
      sy_in = pa_ff * $signed({1'b0, ify_ff});
      sz_in = pb_ff * $signed({1'b0, ify_ff});
      // s3
      r_in[0] = 64'(xn_ff) <<< 14;
      r_in[1] = (64'(ct_ff) <<< 33) - 64'(sy_ff);
      rz_in   = -64'(sz_ff) - (64'(st_ff) <<< 33);
      // s4
      dneg  = -rz_ff;
      d4_in = dneg[61:0];
      for (int l = 0; l < 2; l++) begin
         rneg[l]    = -r_ff[l];
         neg4_in[l] = r_ff[l][63];
         mag_in[l]  = r_ff[l][63] ? rneg[l][61:0] : r_ff[l][61:0];
         // s5
         pl_in[l] = {31'b0, h_ff} * {31'b0, mag_ff[l][30:0]};
         ph_in[l] = {31'b0, h_ff} * {31'b0, mag_ff[l][61:31]};
         // s6
         prod_in[l] = {ph_ff[l], 31'b0} + {31'b0, pl_ff[l]};
         // divider entry: twice the product, keeps the rounding bit
         num[l]              = {prod_ff[l], 1'b0};
         lane_in[0][l].rem   = {10'b0, num[l][93:DIV_BITS]};
         lane_in[0][l].nlow  = num[l][DIV_BITS-1:0];
         lane_in[0][l].quo   = '0;
         lane_in[0][l].ovf   = {10'b0, num[l][93:DIV_BITS]} >= d6_ff;
         lane_in[0][l].neg   = neg6_ff[l];
      end
      // restoring division, one quotient bit per stage
      for (int k = 0; k < DIV_BITS; k++) begin
         for (int l = 0; l < 2; l++) begin
            div_r2[k][l] = {lane_ff[k][l].rem, lane_ff[k][l].nlow[DIV_BITS-1]};
            div_df[k][l] = div_r2[k][l] - {1'b0, dd_ff[k]};
            lane_in[k+1][l]      = lane_ff[k][l];
            lane_in[k+1][l].nlow = {lane_ff[k][l].nlow[DIV_BITS-2:0], 1'b0};
            if (div_r2[k][l] >= {1'b0, dd_ff[k]}) begin
               lane_in[k+1][l].rem = div_df[k][l][61:0];
               lane_in[k+1][l].quo = {lane_ff[k][l].quo[DIV_BITS-2:0], 1'b1};
            end else begin
               lane_in[k+1][l].rem = div_r2[k][l][61:0];
               lane_in[k+1][l].quo = {lane_ff[k][l].quo[DIV_BITS-2:0], 1'b0};
            end
         end
      end
      // round half up, cap, offset from camera
      cam43[0] = 43'(camx_ff);
      cam43[1] = 43'(camy_ff);
      for (int l = 0; l < 2; l++) begin
         tp1[l] = {1'b0, lane_ff[DIV_BITS][l].quo} + (DIV_BITS+1)'(1);
         qr[l]  = tp1[l][DIV_BITS:1];
         qc[l]  = (lane_ff[DIV_BITS][l].ovf || qr[l] > Q_CAP) ? Q_CAP : qr[l];
         v_in[l] = lane_ff[DIV_BITS][l].neg ? cam43[l] - $signed({1'b0, qc[l]})
                                            : cam43[l] + $signed({1'b0, qc[l]});
         // clamp
         s_in[l] = 1'b0;
         if (v_ff[l] > 43'sd2147483647) begin
            o_in[l] = 32'h7fff_ffff;
            s_in[l] = 1'b1;
         end else if (v_ff[l] < -43'sd2147483648) begin
            o_in[l] = 32'h8000_0000;
            s_in[l] = 1'b1;
         end else begin
            o_in[l] = v_ff[l][31:0];
         end
      end
      if (upr_ff) begin
         o_in[0] = camx_ff;
         o_in[1] = camy_ff;
         s_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         du2_ff <= du2_in;
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         xn_ff  <= xn_in;
         sy_ff  <= sy_in;
         sz_ff  <= sz_in;
         r_ff   <= r_in;
         rz_ff  <= rz_in;
         mag_ff <= mag_in;
         neg4_ff <= neg4_in;
         d4_ff  <= d4_in;
         up4_ff <= !rz_ff[63];
         pl_ff  <= pl_in;
         ph_ff  <= ph_in;
         neg5_ff <= neg4_ff;
         d5_ff  <= d4_ff;
         up5_ff <= up4_ff;
         prod_ff <= prod_in;
         neg6_ff <= neg5_ff;
         d6_ff  <= d5_ff;
         up6_ff <= up5_ff;
         lane_ff <= lane_in;
         dd_ff[0]  <= d6_ff;
         upd_ff[0] <= up6_ff;
         for (int k = 0; k < DIV_BITS; k++) begin
            dd_ff[k+1]  <= dd_ff[k];
            upd_ff[k+1] <= upd_ff[k];
         end
         v_ff   <= v_in;
         upr_ff <= upd_ff[DIV_BITS];
         o_ff   <= o_in;
         sat_ff <= |s_in;
         upo_ff <= upr_ff;
      end
   end

endmodule
